@@ hdl/btmx_pkg.sv @@
// Shared types and constants for the binary trie maximum-xor block.
package btmx_pkg;

    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 16384;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = NODE_W + 1;
    localparam int BIT_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int FULL_LIMIT = NODE_COUNT - KEY_BITS;

    typedef logic [NODE_W-1:0]        node_t;
    typedef logic [1:0][NODE_W-1:0]   link_pair_t;
    typedef logic [KEY_BITS-1:0]      key_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

@@ hdl/btmx_if.sv @@
// Request and response channel interfaces for the binary trie maximum-xor block.
interface btmx_req_if import btmx_pkg::*; ();
    logic  valid;
    logic  ready;
    op_t   op;
    key_t  key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface btmx_rsp_if import btmx_pkg::*; ();
    logic    valid;
    logic    ready;
    key_t    max_xor;
    status_t status;

    modport source (output valid, output max_xor, output status, input ready);
    modport sink   (input valid, input max_xor, input status, output ready);
endinterface

@@ hdl/binary_trie_max_xor.sv @@
// Top level of the binary trie maximum-xor block: node store, walk sequencer and output register.
// Each request either inserts a key into the trie or asks for the largest xor of its key with any
// stored key. The trie walks one level per cycle through a single node store with a registered
// read. A request that walks the trie goes from idle to the root state and then level by level
// to the result state, which loads its result into the response register. The next request is taken
// only once the block is back in idle. A query on an empty trie or an insert refused for a full
// store goes straight from idle to the result state. A result that the sink has not yet taken
// holds the following one in its final state, which stalls further requests. Nodes come from a
// bump counter that only reset rewinds, and an insert is refused when fewer than KEY_BITS nodes
// remain. The node store needs no clearing after reset. The response register lets a finished
// result wait while the next request is accepted and walked.
module binary_trie_max_xor import btmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    btmx_req_if.sink    req,
    btmx_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_WALK,
        S_CHAIN,
        S_RESULT
    } state_t;

    state_t      state_reg,   state_next;
    op_t         op_reg,      op_next;
    key_t        key_reg,     key_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    node_t       cur_reg,     cur_next;
    logic [FREE_W-1:0] free_reg, free_next;
    link_pair_t  root_reg,    root_next;
    key_t        acc_reg,     acc_next;
    status_t     stat_reg,    stat_next;
    logic        rsp_valid_reg,   rsp_valid_next;
    key_t        rsp_max_xor_reg, rsp_max_xor_next;
    status_t     rsp_status_reg,  rsp_status_next;

    link_pair_t  node_mem [NODE_COUNT];
    link_pair_t  mem_rdata_reg;
    node_t       mem_raddr;
    node_t       mem_waddr;
    link_pair_t  mem_wdata;
    logic        mem_we;

    link_pair_t  links;
    logic        kb;
    node_t       same_link;
    node_t       opp_link;
    node_t       new_node;
    logic        last_level;

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.max_xor = rsp_max_xor_reg;
    assign rsp.status  = rsp_status_reg;

    always_comb
    begin
        links      = (state_reg == S_ROOT) ? root_reg : mem_rdata_reg;
        kb         = key_reg[bit_reg];
        same_link  = links[kb];
        opp_link   = links[~kb];
        new_node   = free_reg[NODE_W-1:0];
        last_level = (bit_reg == '0);

        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        bit_next         = bit_reg;
        cur_next         = cur_reg;
        free_next        = free_reg;
        root_next        = root_reg;
        acc_next         = acc_reg;
        stat_next        = stat_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_max_xor_next = rsp_max_xor_reg;
        rsp_status_next  = rsp_status_reg;

        mem_raddr = cur_reg;
        mem_waddr = cur_reg;
        mem_wdata = links;
        mem_we    = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.op;
                    key_next  = req.key;
                    bit_next  = BIT_W'(KEY_BITS - 1);
                    acc_next  = '0;
                    stat_next = STATUS_DONE;
                    if (req.op == OP_QUERY && root_reg == '0)
                    begin
                        stat_next  = STATUS_EMPTY;
                        state_next = S_RESULT;
                    end
                    else if (req.op == OP_INSERT && free_reg > FREE_W'(FULL_LIMIT))
                    begin
                        stat_next  = STATUS_FULL;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_ROOT;
                    end
                end
            end

            S_ROOT, S_WALK:
            begin
                if (op_reg == OP_QUERY)
                begin
                    if (opp_link != '0)
                    begin
                        acc_next[bit_reg] = 1'b1;
                        cur_next          = opp_link;
                    end
                    else
                    begin
                        cur_next = same_link;
                    end
                    mem_raddr = cur_next;
                    bit_next  = bit_reg - 1'b1;
                    if (last_level || (opp_link == '0 && same_link == '0))
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
                else if (same_link != '0)
                begin
                    cur_next   = same_link;
                    mem_raddr  = same_link;
                    bit_next   = bit_reg - 1'b1;
                    state_next = last_level ? S_RESULT : S_WALK;
                end
                else
                begin
                    if (state_reg == S_ROOT)
                    begin
                        root_next[kb] = new_node;
                    end
                    else
                    begin
                        mem_we        = 1'b1;
                        mem_wdata[kb] = new_node;
                    end
                    free_next  = free_reg + 1'b1;
                    cur_next   = new_node;
                    bit_next   = bit_reg - 1'b1;
                    state_next = last_level ? S_RESULT : S_CHAIN;
                end
            end

            S_CHAIN:
            begin
                mem_we        = 1'b1;
                mem_wdata     = '0;
                mem_wdata[kb] = new_node;
                free_next     = free_reg + 1'b1;
                cur_next      = new_node;
                bit_next      = bit_reg - 1'b1;
                if (last_level)
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_max_xor_next = (op_reg == OP_QUERY) ? acc_reg : '0;
                    rsp_status_next  = stat_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            free_reg        <= FREE_W'(1);
            root_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            op_reg          <= OP_INSERT;
            key_reg         <= '0;
            bit_reg         <= '0;
            cur_reg         <= '0;
            acc_reg         <= '0;
            stat_reg        <= STATUS_DONE;
            rsp_max_xor_reg <= '0;
            rsp_status_reg  <= STATUS_DONE;
        end
        else
        begin
            state_reg       <= state_next;
            free_reg        <= free_next;
            root_reg        <= root_next;
            rsp_valid_reg   <= rsp_valid_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            bit_reg         <= bit_next;
            cur_reg         <= cur_next;
            acc_reg         <= acc_next;
            stat_reg        <= stat_next;
            rsp_max_xor_reg <= rsp_max_xor_next;
            rsp_status_reg  <= rsp_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= node_mem[mem_raddr];
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(NODE_COUNT))
        else $error("Node counter ran past the end of the node store.");

    a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (op_reg == OP_INSERT && (state_reg == S_WALK || state_reg == S_CHAIN)))
        else $error("Node store written outside an insert walk.");

    a_chain_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHAIN |-> cur_reg == NODE_W'(free_reg - 1'b1))
        else $error("Chained node is not the most recently allocated one.");

    a_free_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg != $past(free_reg) |-> $past(op_reg == OP_INSERT && state_reg != S_IDLE))
        else $error("Node counter moved outside an insert.");

    a_non_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg != STATUS_DONE) |-> rsp_max_xor_reg == '0)
        else $error("Refused or empty result carries a nonzero value.");

endmodule
